// File: hdl/mmp_pkg.sv
// Shared types, status codes and a helper function for the MIDI message parser.
package mmp_pkg;

   localparam int BYTE_W  = 8;
   localparam int DATA_W  = 7;
   localparam int NIBBLE_W = 4;
   localparam int COUNT_W = 2;

   // Upper nibbles of status bytes that need special length handling.
   localparam logic [NIBBLE_W-1:0] CMD_PROGRAM_CHANGE   = 4'hC;
   localparam logic [NIBBLE_W-1:0] CMD_CHANNEL_PRESSURE = 4'hD;
   localparam logic [NIBBLE_W-1:0] CMD_SYSTEM           = 4'hF;

   // Low nibbles of system messages that carry data bytes.
   localparam logic [NIBBLE_W-1:0] SYS_QUARTER_FRAME = 4'h1;
   localparam logic [NIBBLE_W-1:0] SYS_SONG_POSITION = 4'h2;
   localparam logic [NIBBLE_W-1:0] SYS_SONG_SELECT   = 4'h3;

   localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO  = 2'd2;

   typedef enum logic [1:0] {
      PHASE_WAIT   = 2'd0,
      PHASE_FIRST  = 2'd1,
      PHASE_SECOND = 2'd2
   } phase_type;

   // One result word as it travels from the decoder to the output register.
   typedef struct packed {
      logic [BYTE_W-1:0]   thru_byte;
      logic                msg_valid;
      logic                is_system;
      logic [NIBBLE_W-1:0] command_nibble;
      logic [NIBBLE_W-1:0] low_nibble;
      logic [DATA_W-1:0]   data_first;
      logic [DATA_W-1:0]   data_second;
      logic [COUNT_W-1:0]  data_count;
   } msg_type;

   // Number of data bytes that follow a given status byte.
   function automatic logic [COUNT_W-1:0] data_length(input logic [BYTE_W-1:0] status);
      logic [NIBBLE_W-1:0] cmd;
      logic [NIBBLE_W-1:0] sub;
      logic [COUNT_W-1:0]  len;
      cmd = status[BYTE_W-1 -: NIBBLE_W];
      sub = status[NIBBLE_W-1:0];
      if (cmd == CMD_PROGRAM_CHANGE || cmd == CMD_CHANNEL_PRESSURE) begin
         len = COUNT_ONE;
      end else if (cmd != CMD_SYSTEM) begin
         len = COUNT_TWO;
      end else if (sub == SYS_QUARTER_FRAME || sub == SYS_SONG_SELECT) begin
         len = COUNT_ONE;
      end else if (sub == SYS_SONG_POSITION) begin
         len = COUNT_TWO;
      end else begin
         len = COUNT_NONE;
      end
      return len;
   endfunction

endpackage

// File: hdl/mmp_input_stage.sv
// Input register that captures one received byte per word.
module mmp_input_stage
   import mmp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              advance,
   output logic              byte_valid,
   output logic [BYTE_W-1:0] rx_byte
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              load;

   // The register can take a new word when empty or when its word moves on.
   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign rx_byte    = byte_ff;

endmodule

// File: hdl/mmp_decoder.sv
// Parse state and the combinational decode of one byte into a result word.
module mmp_decoder
   import mmp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [BYTE_W-1:0] rx_byte,
   output msg_type           msg
);

   phase_type           phase_ff;
   phase_type           phase_in;
   logic [BYTE_W-1:0]   status_ff;
   logic [BYTE_W-1:0]   status_in;
   logic [DATA_W-1:0]   first_ff;
   logic [DATA_W-1:0]   first_in;
   logic [COUNT_W-1:0]  expected_ff;
   logic [COUNT_W-1:0]  expected_in;
   logic [COUNT_W-1:0]  len;

   function automatic msg_type emit(input logic [BYTE_W-1:0]  thru,
                                    input logic [BYTE_W-1:0]  status,
                                    input logic [DATA_W-1:0]  d1,
                                    input logic [DATA_W-1:0]  d2,
                                    input logic [COUNT_W-1:0] cnt);
      msg_type m;
      m.thru_byte      = thru;
      m.msg_valid      = 1'b1;
      m.command_nibble = status[BYTE_W-1 -: NIBBLE_W];
      m.is_system      = (status[BYTE_W-1 -: NIBBLE_W] == CMD_SYSTEM);
      m.low_nibble     = status[NIBBLE_W-1:0];
      m.data_first     = d1;
      m.data_second    = d2;
      m.data_count     = cnt;
      return m;
   endfunction

   always_comb begin
      msg           = '0;
      msg.thru_byte = rx_byte;
      phase_in      = phase_ff;
      status_in     = status_ff;
      first_in      = first_ff;
      expected_in   = expected_ff;
      len           = data_length(rx_byte);
      if (rx_byte[BYTE_W-1]) begin
         // A status byte always restarts parsing.
         status_in   = rx_byte;
         expected_in = len;
         if (len == COUNT_NONE) begin
            msg      = emit(rx_byte, rx_byte, '0, '0, COUNT_NONE);
            phase_in = PHASE_WAIT;
         end else begin
            phase_in = PHASE_FIRST;
         end
      end else begin
         case (phase_ff)
            PHASE_FIRST: begin
               if (expected_ff == COUNT_ONE) begin
                  msg      = emit(rx_byte, status_ff, rx_byte[DATA_W-1:0], '0, COUNT_ONE);
                  phase_in = PHASE_WAIT;
               end else begin
                  first_in = rx_byte[DATA_W-1:0];
                  phase_in = PHASE_SECOND;
               end
            end
            PHASE_SECOND: begin
               msg      = emit(rx_byte, status_ff, first_ff, rx_byte[DATA_W-1:0], COUNT_TWO);
               phase_in = PHASE_WAIT;
            end
            default: begin
               phase_in = PHASE_WAIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_WAIT;
         status_ff   <= '0;
         first_ff    <= '0;
         expected_ff <= COUNT_NONE;
      end else if (fire) begin
         phase_ff    <= phase_in;
         status_ff   <= status_in;
         first_ff    <= first_in;
         expected_ff <= expected_in;
      end
   end

endmodule

// File: hdl/mmp_output_stage.sv
// Result register that holds one result word until the receiver takes it.
module mmp_output_stage
   import mmp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  msg_type             load_msg,
   output logic                can_take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_thru_byte,
   output logic                rsp_msg_valid,
   output logic                rsp_is_system,
   output logic [NIBBLE_W-1:0] rsp_command_nibble,
   output logic [NIBBLE_W-1:0] rsp_low_nibble,
   output logic [DATA_W-1:0]   rsp_data_first,
   output logic [DATA_W-1:0]   rsp_data_second,
   output logic [COUNT_W-1:0]  rsp_data_count
);

   logic    valid_ff;
   logic    valid_in;
   msg_type msg_ff;

   assign can_take = !valid_ff || !rsp_stall;
   assign valid_in = can_take ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_take && load_valid) begin
         msg_ff <= load_msg;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_thru_byte      = msg_ff.thru_byte;
   assign rsp_msg_valid      = msg_ff.msg_valid;
   assign rsp_is_system      = msg_ff.is_system;
   assign rsp_command_nibble = msg_ff.command_nibble;
   assign rsp_low_nibble     = msg_ff.low_nibble;
   assign rsp_data_first     = msg_ff.data_first;
   assign rsp_data_second    = msg_ff.data_second;
   assign rsp_data_count     = msg_ff.data_count;

endmodule

// File: hdl/midi_message_parser.sv
// Top level of the MIDI message parser: input register, decoder, result register.
//
// The parser takes one received MIDI byte per input word and returns exactly one
// result word for it. Every byte comes back unchanged on rsp_thru_byte. A status
// byte (0x80 and above) starts a new message, and its data length follows from
// the command nibble: one byte for program change and channel pressure, two for
// the other channel messages; for system messages one byte for quarter frame and
// song select, two for song position and none for the rest. When a byte completes
// a message, rsp_msg_valid is high and the status nibbles and data bytes of that
// message appear on the result; otherwise those fields are zero. A status byte in
// the middle of a message drops the partial message, and data bytes that arrive
// while no message is open are ignored, so running status and system exclusive
// payload produce no messages. A word accepted into the input register moves into
// the result register when the result register can take it, and its result is
// presented from there; with no stall on the result side a new word is accepted
// in every cycle. The parse state advances as a word moves from the input
// register into the result register, through a single short decode step. A
// stall on the result side holds the result register and, once the input
// register is also full, raises req_stall in the same cycle. There is no
// configuration.
module midi_message_parser
   import mmp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_thru_byte,
   output logic                rsp_msg_valid,
   output logic                rsp_is_system,
   output logic [NIBBLE_W-1:0] rsp_command_nibble,
   output logic [NIBBLE_W-1:0] rsp_low_nibble,
   output logic [DATA_W-1:0]   rsp_data_first,
   output logic [DATA_W-1:0]   rsp_data_second,
   output logic [COUNT_W-1:0]  rsp_data_count
);

   logic              byte_valid;
   logic [BYTE_W-1:0] rx_byte;
   logic              can_take;
   logic              fire;
   msg_type           msg;

   // A word leaves the input register exactly when the result register takes it;
   // that is also the only moment the parse state may change.
   assign fire = byte_valid && can_take;

   mmp_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (can_take),
      .byte_valid  (byte_valid),
      .rx_byte     (rx_byte)
   );

   mmp_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_byte (rx_byte),
      .msg     (msg)
   );

   mmp_output_stage u_output (
      .clock              (clock),
      .reset              (reset),
      .load_valid         (byte_valid),
      .load_msg           (msg),
      .can_take           (can_take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_thru_byte      (rsp_thru_byte),
      .rsp_msg_valid      (rsp_msg_valid),
      .rsp_is_system      (rsp_is_system),
      .rsp_command_nibble (rsp_command_nibble),
      .rsp_low_nibble     (rsp_low_nibble),
      .rsp_data_first     (rsp_data_first),
      .rsp_data_second    (rsp_data_second),
      .rsp_data_count     (rsp_data_count)
   );

endmodule
